/* rtl/core/wsgs_pkg.sv */
// Package for the wave stencil grid stepper core.
// Holds the grid constants, command codes and the controller/datapath control structs.
// Has no dependencies.
package wsgs_pkg;

	localparam int GridSize   = 64;
	localparam int ValueWidth = 24;
	localparam int FracBits   = 20;
	localparam int IdxWidth   = $clog2(GridSize);
	localparam int AddrWidth  = 2 * IdxWidth;

	localparam int MaskRowLo  = GridSize / 4;
	localparam int MaskRowHi  = (GridSize * 9) / 32;
	localparam int Slit1Lo    = (GridSize * 5) / 16;
	localparam int Slit1Hi    = (GridSize * 3) / 8;
	localparam int Slit2Lo    = (GridSize * 5) / 8;
	localparam int Slit2Hi    = (GridSize * 11) / 16;

	typedef logic signed [ValueWidth-1:0] value_t;
	typedef logic [IdxWidth-1:0]          idx_t;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_PROF  = 2'd3
	} action_t;

	// Datapath operation selected by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_FETCH,
		OP_CELL,
		OP_DRIVE,
		OP_READ,
		OP_PROF
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		idx_t   i;
		idx_t   j;
		logic   load_cmd;
		logic   flip_bank;
		logic   reset_bank;
		logic   clear_prof;
	} dp_ctrl_t;

	typedef struct packed {
		logic   cell_done;
	} dp_stat_t;

	function automatic value_t sat_value(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (ValueWidth - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi)
			return value_t'(hi);
		else if (x < lo)
			return value_t'(lo);
		return value_t'(x);
	endfunction

	function automatic logic cell_masked(input idx_t i, input idx_t j);
		logic slit;
		if (i == '0 || j == '0 || i == idx_t'(GridSize - 1) || j == idx_t'(GridSize - 1))
			return 1'b1;
		slit = (j >= idx_t'(Slit1Lo) && j < idx_t'(Slit1Hi)) ||
		       (j >= idx_t'(Slit2Lo) && j < idx_t'(Slit2Hi));
		if (i >= idx_t'(MaskRowLo) && i < idx_t'(MaskRowHi))
			return !slit;
		return 1'b0;
	endfunction

endpackage

/* rtl/core/wave_stencil_grid_stepper_core.sv */
// Top level of the wave stencil grid stepper: controller plus datapath.
// Depends on wsgs_pkg, wsgs_ctrl and wsgs_datapath.
//
// After reset the block holds busy high while it zeroes both field banks and the drive
// profile. A step holds busy while it visits all 4096 cells, as the single read port of
// each field bank fetches the four neighbours and the previous value in turn, then 62
// drive cells, as the profile word is read, multiplied by the amplitude and written into
// row 0 of the current field bank. A clear zeroes both field banks, one cell per cycle.
// A read returns cell_value with a one-cycle valid strobe, once the bank word has been
// registered and then copied into cell_value; a profile write stores one profile word.
// The receiver cannot stall: read the result when valid is high.
module wave_stencil_grid_stepper_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [23:0] value,
	output logic               valid,
	output logic signed [23:0] cell_value
);
	import wsgs_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	wsgs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.stat(stat), .busy(busy), .ctrl(ctrl)
	);

	wsgs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .row(row), .col(col),
		.value(value), .stat(stat), .read_done(valid), .cell_value(cell_value)
	);
endmodule

/* rtl/core/wsgs_datapath.sv */
// Datapath of the wave stencil grid stepper: field banks, profile store and stencil arithmetic.
// Depends on wsgs_pkg.
module wsgs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  wsgs_pkg::dp_ctrl_t ctrl,
	input  logic [5:0]        row,
	input  logic [5:0]        col,
	input  logic signed [23:0] value,
	output wsgs_pkg::dp_stat_t stat,
	output logic              read_done,
	output logic signed [23:0] cell_value
);
	import wsgs_pkg::*;

	// Bank memories. Each cycle reads one word from one of the two banks; a cell visit
	// issues its five reads in turn.
	value_t bank_a [GridSize*GridSize];
	value_t bank_b [GridSize*GridSize];
	value_t prof   [GridSize];

	logic   cur_q;
	value_t amp_q;
	logic [5:0] row_q;
	logic [5:0] col_q;
	value_t val_q;
	logic [2:0] ph_q;
	logic signed [ValueWidth+2:0] sum_q;
	value_t rd_a_q;
	value_t rd_b_q;
	value_t prof_rd_q;
	logic signed [2*ValueWidth-1:0] prod_q;
	logic [1:0] drv_ph_q;
	logic       rd_v_q;
	logic       wr_en;
	logic       wr_bank;
	logic [AddrWidth-1:0] wr_addr;
	value_t     wr_data;
	logic [AddrWidth-1:0] rd_addr;
	logic       rd_bank;
	idx_t       up;
	idx_t       dn;
	idx_t       lf;
	idx_t       rt;
	logic signed [ValueWidth+3:0] num;
	logic signed [ValueWidth+3:0] half;
	logic signed [2*ValueWidth:0] drv;

	assign up = ctrl.i - idx_t'(1);
	assign dn = ctrl.i + idx_t'(1);
	assign lf = ctrl.j - idx_t'(1);
	assign rt = ctrl.j + idx_t'(1);

	// Read address per phase: 0 left, 1 right, 2 up, 3 down from the current bank,
	// 4 and later the previous value from the other bank.
	always_comb begin
		rd_bank = cur_q;
		unique case (ph_q)
			3'd0: rd_addr = {ctrl.i, lf};
			3'd1: rd_addr = {ctrl.i, rt};
			3'd2: rd_addr = {up, ctrl.j};
			3'd3: rd_addr = {dn, ctrl.j};
			default: begin
				rd_addr = {ctrl.i, ctrl.j};
				rd_bank = ~cur_q;
			end
		endcase
		if (ctrl.op == OP_READ) begin
			rd_addr = {row_q[IdxWidth-1:0], col_q[IdxWidth-1:0]};
			rd_bank = cur_q;
		end
	end

	assign num  = (ValueWidth+4)'(sum_q) - ((ValueWidth+4)'(rd_b_q) <<< 1);
	assign half = (num + (ValueWidth+4)'(1)) >>> 1;
	assign drv  = ((2*ValueWidth+1)'(prod_q) + ((2*ValueWidth+1)'(1) <<< (FracBits - 1)))
	              >>> FracBits;

	always_comb begin
		wr_en   = 1'b0;
		wr_bank = ~cur_q;
		wr_addr = {ctrl.i, ctrl.j};
		wr_data = '0;
		unique case (ctrl.op)
			OP_CLEAR: begin
				wr_en = 1'b1;
			end
			OP_CELL: begin
				if (ph_q == 3'd6) begin
					wr_en   = 1'b1;
					wr_data = cell_masked(ctrl.i, ctrl.j) ? '0 : sat_value(64'(half));
				end
			end
			OP_DRIVE: begin
				if (drv_ph_q == 2'd2) begin
					wr_en   = 1'b1;
					wr_bank = cur_q;
					wr_addr = {idx_t'(0), ctrl.j};
					wr_data = sat_value(64'(drv));
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && (ctrl.op == OP_CLEAR || !wr_bank))
			bank_a[wr_addr] <= wr_data;
		if (wr_en && (ctrl.op == OP_CLEAR || wr_bank))
			bank_b[wr_addr] <= wr_data;
		if (ctrl.clear_prof)
			prof[ctrl.j] <= '0;
		else if (ctrl.op == OP_PROF)
			prof[col_q[IdxWidth-1:0]] <= val_q;
		rd_b_q <= rd_bank ? bank_b[rd_addr] : bank_a[rd_addr];
		rd_a_q <= rd_bank ? bank_b[rd_addr] : bank_a[rd_addr];
		prof_rd_q <= prof[ctrl.j];
		if (ctrl.load_cmd) begin
			row_q <= row;
			col_q <= col;
			val_q <= sat_value(64'(value));
			amp_q <= sat_value(64'(value));
		end
		unique case (ph_q)
			3'd1: sum_q <= (ValueWidth+3)'(rd_a_q);
			3'd2, 3'd3, 3'd4: sum_q <= sum_q + (ValueWidth+3)'(rd_a_q);
			default: sum_q <= sum_q;
		endcase
		prod_q <= amp_q * prof_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= 1'b0;
			ph_q      <= '0;
			drv_ph_q  <= '0;
			rd_v_q    <= 1'b0;
			read_done <= 1'b0;
			cell_value <= '0;
		end else begin
			if (ctrl.reset_bank)
				cur_q <= 1'b0;
			else if (ctrl.flip_bank)
				cur_q <= ~cur_q;
			if (ctrl.op == OP_CELL)
				ph_q <= (ph_q == 3'd6) ? 3'd0 : ph_q + 3'd1;
			else
				ph_q <= '0;
			if (ctrl.op == OP_DRIVE)
				drv_ph_q <= (drv_ph_q == 2'd2) ? 2'd0 : drv_ph_q + 2'd1;
			else
				drv_ph_q <= '0;
			rd_v_q    <= (ctrl.op == OP_READ);
			read_done <= rd_v_q;
			if (rd_v_q)
				cell_value <= rd_a_q;
		end
	end

	assign stat.cell_done = ((ctrl.op == OP_CELL) && (ph_q == 3'd6)) ||
	                        ((ctrl.op == OP_DRIVE) && (drv_ph_q == 2'd2));

	dp_read_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		read_done |-> $past(rd_v_q)) else $error("read strobe without a read");
	dp_drive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(drv_ph_q != 2'd0) |-> $past(ctrl.op == OP_DRIVE)) else $error("drive write out of order");
	dp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != 3'd0) |-> $past(ctrl.op == OP_CELL)) else $error("stray phase");
endmodule

/* rtl/core/wsgs_ctrl.sv */
// Controller state machine of the wave stencil grid stepper.
// Depends on wsgs_pkg.
module wsgs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         action,
	input  wsgs_pkg::dp_stat_t stat,
	output logic               busy,
	output wsgs_pkg::dp_ctrl_t ctrl
);
	import wsgs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_CLEAR, S_CELLS, S_DRIVE, S_READ, S_RWAIT, S_PROF
	} state_t;

	state_t state_q;
	idx_t   i_q;
	idx_t   j_q;
	logic   acc;
	logic   last_j;
	logic   last_i;

	assign acc    = start && !busy;
	assign last_j = (j_q == idx_t'(GridSize - 1));
	assign last_i = (i_q == idx_t'(GridSize - 1));

	always_comb begin
		ctrl.i          = i_q;
		ctrl.j          = j_q;
		ctrl.load_cmd   = acc;
		ctrl.flip_bank  = 1'b0;
		ctrl.reset_bank = 1'b0;
		ctrl.clear_prof = 1'b0;
		unique case (state_q)
			S_INIT: begin
				ctrl.op         = OP_CLEAR;
				ctrl.reset_bank = 1'b1;
				ctrl.clear_prof = (i_q == '0);
			end
			S_CLEAR: begin
				ctrl.op         = OP_CLEAR;
				ctrl.reset_bank = 1'b1;
			end
			S_CELLS: begin
				ctrl.op        = OP_CELL;
				ctrl.flip_bank = stat.cell_done && last_i && last_j;
			end
			S_DRIVE:  ctrl.op = OP_DRIVE;
			S_READ:   ctrl.op = OP_READ;
			S_PROF:   ctrl.op = OP_PROF;
			default:  ctrl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy    <= 1'b1;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						busy <= 1'b1;
						i_q  <= '0;
						j_q  <= '0;
						unique case (action_t'(action))
							ACT_CLEAR: state_q <= S_CLEAR;
							ACT_STEP:  state_q <= S_CELLS;
							ACT_READ:  state_q <= S_READ;
							default:   state_q <= S_PROF;
						endcase
					end
				end
				S_INIT, S_CLEAR: begin
					j_q <= j_q + idx_t'(1);
					if (last_j) begin
						i_q <= i_q + idx_t'(1);
						if (last_i) begin
							state_q <= S_IDLE;
							busy    <= 1'b0;
						end
					end
				end
				S_CELLS: begin
					if (stat.cell_done) begin
						j_q <= j_q + idx_t'(1);
						if (last_j) begin
							i_q <= i_q + idx_t'(1);
							if (last_i) begin
								state_q <= S_DRIVE;
								j_q     <= idx_t'(1);
							end
						end
					end
				end
				S_DRIVE: begin
					if (stat.cell_done) begin
						j_q <= j_q + idx_t'(1);
						if (j_q == idx_t'(GridSize - 2)) begin
							state_q <= S_IDLE;
							busy    <= 1'b0;
						end
					end
				end
				S_READ:  state_q <= S_RWAIT;
				S_RWAIT: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	ctl_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> busy) else $error("busy low while working");
	ctl_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> busy) else $error("accepted item left block idle");
	ctl_flip: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flip_bank |=> (state_q == S_DRIVE)) else $error("bank flip out of place");
endmodule
